// ===== sv/ippe_pkg.sv =====
package ippe_pkg;

  localparam int PAL_DEPTH = 256;
  localparam int IDX_W     = $clog2(PAL_DEPTH);
  localparam logic [8:0] PAL_LIMIT = 9'(PAL_DEPTH);

  localparam int ENTRY_W = 24;
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] HI_MASK = 8'hf0;
  localparam logic [7:0] LO_MASK = 8'h0f;

  typedef enum logic [1:0] {
    CMD_PACKED12 = 2'd0,
    CMD_RGB24    = 2'd1,
    CMD_PIXEL    = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_e;

  typedef enum logic {
    REG_PIXEL_MODE = 1'b0,
    REG_ROW_WIDTH  = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    Q_WRITE = 1'b0,
    Q_PIXEL = 1'b1
  } q_kind_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  palette_index;
    logic [23:0] entry_data;
    logic [7:0]  pixel_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       end_of_row;
    logic       last;
  } out_item_t;

  // palette write: idx = entry, data = rgb (expanded if packed12); pixel: idx = pixel byte
  typedef struct packed {
    q_kind_e             kind;
    logic [7:0]          idx;
    logic [ENTRY_W-1:0]  data;
  } q_item_t;

  typedef struct packed {
    logic    valid;
    q_item_t item;
  } q_head_t;

  typedef struct packed {
    logic        pixel_mode;
    logic [15:0] row_width;
  } cfg_t;

endpackage

// ===== sv/ippe_ram.sv =====
module ippe_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/ippe_front.sv =====
module ippe_front import ippe_pkg::*; (
  input  logic     in_valid_i,
  input  in_item_t in_data_i,
  input  logic     q_full_i,
  output logic     in_stall_o,
  output logic     push_o,
  output q_item_t  push_item_o
);

  logic [7:0] b0;
  logic [7:0] b1;
  logic [7:0] red_n;
  logic [7:0] grn_n;
  logic [7:0] blu_n;
  logic       idx_ok;
  logic       keep;

  always_comb begin
    b0     = in_data_i.entry_data[7:0];
    b1     = in_data_i.entry_data[15:8] & LO_MASK;
    red_n  = b0 & HI_MASK;
    grn_n  = {b1[3:0], 4'h0};
    blu_n  = {b0[3:0], 4'h0};
    idx_ok = {1'b0, in_data_i.palette_index} < PAL_LIMIT;

    push_item_o.kind = Q_WRITE;
    push_item_o.idx  = in_data_i.palette_index;
    push_item_o.data = in_data_i.entry_data;
    keep             = 1'b0;

    case (cmd_e'(in_data_i.command))
      CMD_PACKED12: begin
        push_item_o.data = {red_n, grn_n, blu_n};
        keep             = idx_ok;
      end
      CMD_RGB24: begin
        keep = idx_ok;
      end
      CMD_PIXEL: begin
        push_item_o.kind = Q_PIXEL;
        push_item_o.idx  = in_data_i.pixel_byte;
        keep             = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i & ~q_full_i & keep;

endmodule

// ===== sv/ippe_queue.sv =====
module ippe_queue import ippe_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  q_item_t push_item_i,
  input  logic    pop_i,
  output q_head_t head_o,
  output logic    full_o
);

  q_item_t              buf_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_q, wr_d;
  logic [Q_PTR_W-1:0]   rd_q, rd_d;
  logic [Q_CNT_W-1:0]   cnt_q, cnt_d;
  logic                 do_pop;

  assign do_pop      = pop_i & (cnt_q != '0);
  assign full_o      = cnt_q == Q_CNT_W'(Q_DEPTH);
  assign head_o.valid = cnt_q != '0;
  assign head_o.item  = buf_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + Q_CNT_W'(push_i) - Q_CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Q_CNT_W'(Q_DEPTH))
    else $error("queue count out of range");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o || do_pop)
    else $error("push into full queue");

  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !do_pop) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue count lost a push");

endmodule

// ===== sv/ippe_back.sv =====
module ippe_back import ippe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  q_head_t   head_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  logic             lo_v_q, lo_v_d;
  logic [3:0]       lo_idx_q, lo_idx_d;
  logic [15:0]      col_q, col_d;
  logic             rd_v_q, rd_v_d;
  logic             rd_zero_q, rd_eor_q, rd_last_q;
  logic             out_v_q, out_v_d;
  out_item_t        out_q, out_d;

  logic             rd_adv;
  logic             can_issue;
  logic             issue;
  logic [7:0]       iss_idx;
  logic             iss_last;
  logic             iss_zero;
  logic             we;
  logic [16:0]      eff;
  logic [16:0]      nxt;
  logic             ends;
  logic [ENTRY_W-1:0] rdata;

  ippe_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (PAL_DEPTH)
  ) u_pal (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (head_i.item.idx[IDX_W-1:0]),
    .wdata_i (head_i.item.data),
    .re_i    (issue),
    .raddr_i (iss_idx[IDX_W-1:0]),
    .rdata_o (rdata)
  );

  assign rd_adv    = rd_v_q & (~out_v_q | ~out_stall_i);
  assign can_issue = ~rd_v_q | rd_adv;

  always_comb begin
    eff  = (cfg_i.row_width == '0) ? 17'h10000 : {1'b0, cfg_i.row_width};
    nxt  = {1'b0, col_q} + 17'd1;
    ends = nxt >= eff;

    pop_o    = 1'b0;
    issue    = 1'b0;
    iss_idx  = '0;
    iss_last = 1'b0;
    we       = 1'b0;
    lo_v_d   = lo_v_q;
    lo_idx_d = lo_idx_q;

    if (lo_v_q) begin
      if (can_issue) begin
        issue    = 1'b1;
        iss_idx  = {4'h0, lo_idx_q};
        iss_last = 1'b1;
        lo_v_d   = 1'b0;
      end
    end else if (head_i.valid) begin
      case (head_i.item.kind)
        Q_WRITE: begin
          we    = 1'b1;
          pop_o = 1'b1;
        end
        Q_PIXEL: begin
          if (can_issue) begin
            pop_o = 1'b1;
            issue = 1'b1;
            if (cfg_i.pixel_mode) begin
              iss_idx  = head_i.item.idx;
              iss_last = 1'b1;
            end else begin
              iss_idx  = {4'h0, head_i.item.idx[7:4]};
              iss_last = ends;
              if (!ends) begin
                lo_v_d   = 1'b1;
                lo_idx_d = head_i.item.idx[3:0];
              end
            end
          end
        end
        default: begin
          pop_o = 1'b1;
        end
      endcase
    end

    iss_zero = ~({1'b0, iss_idx} < PAL_LIMIT);
    col_d    = col_q;
    if (issue) begin
      col_d = ends ? '0 : nxt[15:0];
    end

    rd_v_d = issue | (rd_v_q & ~rd_adv);

    out_d            = out_q;
    out_d.red        = rd_zero_q ? '0 : rdata[23:16];
    out_d.green      = rd_zero_q ? '0 : rdata[15:8];
    out_d.blue       = rd_zero_q ? '0 : rdata[7:0];
    out_d.end_of_row = rd_eor_q;
    out_d.last       = rd_last_q;
    out_v_d          = rd_adv | (out_v_q & out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_v_q  <= 1'b0;
      col_q   <= '0;
      rd_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      lo_v_q  <= lo_v_d;
      col_q   <= col_d;
      rd_v_q  <= rd_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_idx_q <= lo_idx_d;
    if (issue) begin
      rd_zero_q <= iss_zero;
      rd_eor_q  <= ends;
      rd_last_q <= iss_last;
    end
    if (rd_adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  a_lo_only_4bpp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lo_v_q |-> !cfg_i.pixel_mode)
    else $error("pending low nibble in 8bpp mode");

  a_first_half: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && !iss_last) |=> lo_v_q)
    else $error("high nibble issued without pending low nibble");

  a_rd_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_v_q && !rd_adv) |=> rd_v_q && $stable(rd_last_q) && $stable(rd_eor_q))
    else $error("read stage lost a held lookup");

  a_no_pop_midbyte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lo_v_q |-> !pop_o)
    else $error("queue popped while a low nibble waits");

endmodule

// ===== sv/indexed_pixel_palette_expander_unit.sv =====
// Channel | Direction | Handshake                | Payload
// in      | input     | in_valid_i / in_stall_o  | in_data_i  (in_item_t)
// out     | output    | out_valid_o / out_stall_i| out_data_o (out_item_t)
// cfg     | input     | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// Items enter every cycle while the 4-entry queue has room and pass the queue, palette
// read and output registers. Back end: a 4bpp byte is looked up as high, then low nibble,
// unless the high one ends the row (one read port, one pixel per cycle when not stalled).
// Palette writes and lookups keep input order; ignored items never reach the back end.
// Reset clears control and column count, sets 4bpp and row width 1; palette is undefined.
// Output stall backs up through the read stage and queue to in_stall_o.
module indexed_pixel_palette_expander_unit import ippe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  cfg_t    cfg_q, cfg_d;
  logic    q_full;
  logic    push;
  q_item_t push_item;
  logic    pop;
  q_head_t head;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_PIXEL_MODE: cfg_d.pixel_mode = cfg_data_i[0];
        REG_ROW_WIDTH:  cfg_d.row_width  = cfg_data_i;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pixel_mode <= 1'b0;
      cfg_q.row_width  <= 16'd1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  ippe_front u_front (
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .q_full_i    (q_full),
    .in_stall_o  (in_stall_o),
    .push_o      (push),
    .push_item_o (push_item)
  );

  ippe_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .head_o      (head),
    .full_o      (q_full)
  );

  ippe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
